// ----- design/ogwa_pkg.sv -----
// ----------------------------------------------------------------------------
// ogwa_pkg
// Shared widths, register indexes, payload and control types for the
// outlier gated window average unit.
// ----------------------------------------------------------------------------
package ogwa_pkg;

  localparam int COORD_BITS  = 20;
  localparam int LEN_W       = 5;
  localparam int RAD_W       = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int SUM_W       = COORD_BITS + LEN_W;
  localparam int LIM_W       = RAD_W + LEN_W;
  localparam int SQ_W        = 2 * LIM_W;
  localparam int ACC_W       = SQ_W + 2;
  localparam int DIV_CNT_W   = $clog2(SUM_W + 1);

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REJECT_RADIUS = 1'd1;

  localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;
  localparam logic [RAD_W-1:0] RAD_RESET = 16'd512;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic                         accepted;
    logic [LEN_W-1:0]             fill_count;
    logic signed [COORD_BITS-1:0] mean_x;
    logic signed [COORD_BITS-1:0] mean_y;
    logic signed [COORD_BITS-1:0] mean_z;
  } out_item_t;

  typedef struct packed {
    logic diff;
    logic square;
    logic update;
    logic drop_old;
    logic clear;
    logic div_start;
  } lane_ctrl_t;

  typedef struct packed {
    logic            over;
    logic            busy;
    logic [SQ_W-1:0] sq;
  } lane_stat_t;

  typedef struct packed {
    logic square;
    logic decide;
  } merge_ctrl_t;

endpackage

// ----- design/outlier_gated_window_average_3d_unit.sv -----
// ----------------------------------------------------------------------------
// outlier_gated_window_average_3d_unit
// Sliding window average of 3D positions with outlier rejection.
// ----------------------------------------------------------------------------
// Usage: present a position on in_data with in_valid; it is taken on a clock
// edge where in_stall is low. in_stall stays high while that transaction is
// in work, so one position is handled at a time. Each transaction returns
// one result on out_data/out_valid: accepted flag, fill count and the
// rounded window mean per axis.
// A position passes the states diff, square, decide, update, start, divide
// and output from accept to out_valid; the serial divider, one per axis
// lane, forms one quotient bit per cycle.
// The result sits in an output register, so the next position is taken
// while out_valid waits; if out_stall holds the old result when a new one
// is done, the unit holds the new result until the register frees up.
// cfg_we writes window_length (index 0, clears the window) or
// reject_radius (index 1); write only while idle.
// Synchronous active-low reset empties the window and sets window_length
// to 16 and reject_radius to 512.
// ----------------------------------------------------------------------------
module outlier_gated_window_average_3d_unit #(
  parameter int MAX_WINDOW = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ogwa_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ogwa_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [ogwa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ogwa_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ogwa_pkg::*;

  localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SLOT_W = LEN_W + 1;
  localparam int ENT_W  = 3 * COORD_BITS;
  localparam logic [LEN_W-1:0] LEN_MAX =
    (MAX_WINDOW > 31) ? 5'd31 : LEN_W'(MAX_WINDOW);
  localparam logic [LEN_W-1:0] LEN_INIT = (LEN_RESET > LEN_MAX) ? LEN_MAX : LEN_RESET;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_SQUARE,
    S_DECIDE,
    S_UPDATE,
    S_START,
    S_DIVIDE,
    S_OUTPUT
  } state_t;

  state_t            state_r;
  logic [LEN_W-1:0]  len_r;
  logic [RAD_W-1:0]  rad_r;
  logic [LEN_W-1:0]  count_r;
  logic [LEN_W-1:0]  oldest_r;
  logic [LIM_W-1:0]  lim_r;
  in_item_t          in_q_r;
  logic [ENT_W-1:0]  rd_q_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic [ENT_W-1:0]  mem [MAX_WINDOW];

  logic              in_acc;
  logic              cfg_len_wr;
  logic [LEN_W-1:0]  len_wr;
  logic              drop;
  logic              reject;
  logic              add;
  logic [SLOT_W-1:0] tail_sum;
  logic [SLOT_W-1:0] tail;
  logic [SLOT_W-1:0] oldest_inc;
  logic [IDX_W-1:0]  wr_idx;
  logic [IDX_W-1:0]  rd_idx;

  lane_ctrl_t        lane_ctrl;
  merge_ctrl_t       merge_ctrl;
  lane_stat_t        stat_x, stat_y, stat_z;
  logic signed [COORD_BITS-1:0] mean_x, mean_y, mean_z;

  assign in_stall   = state_r != S_IDLE;
  assign in_acc     = in_valid && !in_stall;
  assign cfg_len_wr = cfg_we && cfg_index == REG_WINDOW_LENGTH;

  always_comb begin
    len_wr = cfg_data[LEN_W-1:0];
    if (len_wr == '0) begin
      len_wr = 5'd1;
    end
    if (len_wr > LEN_MAX) begin
      len_wr = LEN_MAX;
    end
  end

  assign drop       = count_r >= len_r;
  assign add        = (state_r == S_UPDATE) && !reject;
  assign tail_sum   = {1'b0, oldest_r} + {1'b0, count_r};
  assign tail       = (tail_sum >= {1'b0, len_r}) ? tail_sum - {1'b0, len_r} : tail_sum;
  assign oldest_inc = {1'b0, oldest_r} + 1'b1;
  assign wr_idx     = drop ? IDX_W'(oldest_r) : IDX_W'(tail);
  assign rd_idx     = IDX_W'(oldest_r);

  always_comb begin
    lane_ctrl.diff      = state_r == S_DIFF;
    lane_ctrl.square    = state_r == S_SQUARE;
    lane_ctrl.update    = add;
    lane_ctrl.drop_old  = drop;
    lane_ctrl.clear     = cfg_len_wr;
    lane_ctrl.div_start = state_r == S_START;
    merge_ctrl.square   = state_r == S_SQUARE;
    merge_ctrl.decide   = state_r == S_DECIDE;
  end

  always_ff @(posedge clk) begin
    if (add) begin
      mem[wr_idx] <= {in_q_r.pos_z, in_q_r.pos_y, in_q_r.pos_x};
    end
    if (in_acc) begin
      rd_q_r <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_q_r <= in_data;
      lim_r  <= count_r * rad_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= LEN_INIT;
      rad_r       <= RAD_RESET;
      count_r     <= '0;
      oldest_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_len_wr) begin
        len_r    <= len_wr;
        count_r  <= '0;
        oldest_r <= '0;
      end
      if (cfg_we && cfg_index == REG_REJECT_RADIUS) begin
        rad_r <= cfg_data[RAD_W-1:0];
      end
      if (out_valid_r && !out_stall && state_r != S_OUTPUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_DIFF;
          end
        end
        S_DIFF:   state_r <= S_SQUARE;
        S_SQUARE: state_r <= S_DECIDE;
        S_DECIDE: state_r <= S_UPDATE;
        S_UPDATE: begin
          if (add && !cfg_len_wr) begin
            if (drop) begin
              oldest_r <= (oldest_inc >= {1'b0, len_r}) ? '0 : oldest_inc[LEN_W-1:0];
            end else begin
              count_r <= count_r + 1'b1;
            end
          end
          state_r <= S_START;
        end
        S_START:  state_r <= S_DIVIDE;
        S_DIVIDE: begin
          if (!stat_x.busy && !stat_y.busy && !stat_z.busy) begin
            state_r <= S_OUTPUT;
          end
        end
        S_OUTPUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r       <= 1'b1;
            out_r.accepted    <= !reject;
            out_r.fill_count  <= count_r;
            out_r.mean_x      <= mean_x;
            out_r.mean_y      <= mean_y;
            out_r.mean_z      <= mean_z;
            state_r           <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  ogwa_lane u_lane_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (lane_ctrl),
    .pos     (in_q_r.pos_x),
    .old_val (rd_q_r[COORD_BITS-1:0]),
    .cnt     (count_r),
    .lim     (lim_r),
    .stat    (stat_x),
    .mean    (mean_x)
  );

  ogwa_lane u_lane_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (lane_ctrl),
    .pos     (in_q_r.pos_y),
    .old_val (rd_q_r[2*COORD_BITS-1:COORD_BITS]),
    .cnt     (count_r),
    .lim     (lim_r),
    .stat    (stat_y),
    .mean    (mean_y)
  );

  ogwa_lane u_lane_z (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (lane_ctrl),
    .pos     (in_q_r.pos_z),
    .old_val (rd_q_r[3*COORD_BITS-1:2*COORD_BITS]),
    .cnt     (count_r),
    .lim     (lim_r),
    .stat    (stat_z),
    .mean    (mean_z)
  );

  ogwa_merge u_merge (
    .clk      (clk),
    .ctrl     (merge_ctrl),
    .stat_x   (stat_x),
    .stat_y   (stat_y),
    .stat_z   (stat_z),
    .lim      (lim_r),
    .nonempty (count_r != '0),
    .reject   (reject)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- design/ogwa_lane.sv -----
// ----------------------------------------------------------------------------
// ogwa_lane
// One axis: running sum, distance term for the outlier test, and a serial
// restoring divider that forms the rounded window mean.
// ----------------------------------------------------------------------------
module ogwa_lane (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ogwa_pkg::lane_ctrl_t                  ctrl,
  input  logic signed [ogwa_pkg::COORD_BITS-1:0] pos,
  input  logic signed [ogwa_pkg::COORD_BITS-1:0] old_val,
  input  logic [ogwa_pkg::LEN_W-1:0]            cnt,
  input  logic [ogwa_pkg::LIM_W-1:0]            lim,
  output ogwa_pkg::lane_stat_t                  stat,
  output logic signed [ogwa_pkg::COORD_BITS-1:0] mean
);
  import ogwa_pkg::*;

  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic [SUM_W-1:0]         dist_r;
  logic                     over_r;
  logic [SQ_W-1:0]          sq_r;

  logic signed [LEN_W:0]    cnt_s;
  logic signed [SUM_W:0]    prod;
  logic signed [SUM_W:0]    diff;
  logic signed [SUM_W:0]    diff_abs;

  logic [SUM_W-1:0]         dvd_r;
  logic [LEN_W-1:0]         rem_r;
  logic [LEN_W-1:0]         den_r;
  logic                     neg_r;
  logic                     zero_r;
  logic [DIV_CNT_W-1:0]     iter_r;

  logic [SUM_W-1:0]         sum_abs;
  logic [LEN_W:0]           trial;
  logic                     ge;
  logic [LEN_W:0]           trial_sub;
  logic [COORD_BITS-1:0]    q_low;

  assign cnt_s    = {1'b0, cnt};
  assign prod     = cnt_s * pos;
  assign diff     = prod - (SUM_W + 1)'(sum_r);
  assign diff_abs = diff[SUM_W] ? -diff : diff;

  always_comb begin
    sum_nxt = sum_r + SUM_W'(pos);
    if (ctrl.drop_old) begin
      sum_nxt = sum_nxt - SUM_W'(old_val);
    end
  end

  assign sum_abs   = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign trial     = {rem_r, dvd_r[SUM_W-1]};
  assign ge        = trial >= {1'b0, den_r};
  assign trial_sub = trial - {1'b0, den_r};
  assign q_low     = dvd_r[COORD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      iter_r <= '0;
    end else begin
      if (ctrl.clear) begin
        sum_r <= '0;
      end else if (ctrl.update) begin
        sum_r <= sum_nxt;
      end
      if (ctrl.div_start) begin
        iter_r <= DIV_CNT_W'(SUM_W);
      end else if (iter_r != '0) begin
        iter_r <= iter_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.diff) begin
      dist_r <= diff_abs[SUM_W-1:0];
    end
    if (ctrl.square) begin
      over_r <= dist_r > SUM_W'(lim);
      sq_r   <= dist_r[LIM_W-1:0] * dist_r[LIM_W-1:0];
    end
    if (ctrl.div_start) begin
      dvd_r  <= sum_abs + SUM_W'(cnt >> 1);
      rem_r  <= '0;
      den_r  <= cnt;
      neg_r  <= sum_r[SUM_W-1];
      zero_r <= cnt == '0;
    end else if (iter_r != '0) begin
      dvd_r <= {dvd_r[SUM_W-2:0], ge};
      rem_r <= ge ? trial_sub[LEN_W-1:0] : trial[LEN_W-1:0];
    end
  end

  assign stat.over = over_r;
  assign stat.busy = iter_r != '0;
  assign stat.sq   = sq_r;

  assign mean = zero_r ? '0 : (neg_r ? $signed(~q_low + 1'b1) : $signed(q_low));

endmodule

// ----- design/ogwa_merge.sv -----
// ----------------------------------------------------------------------------
// ogwa_merge
// Combine the three axis terms: with a nonempty window, reject when any axis
// is already beyond the limit or the squared distance exceeds the squared limit.
// ----------------------------------------------------------------------------
module ogwa_merge (
  input  logic                       clk,
  input  ogwa_pkg::merge_ctrl_t      ctrl,
  input  ogwa_pkg::lane_stat_t       stat_x,
  input  ogwa_pkg::lane_stat_t       stat_y,
  input  ogwa_pkg::lane_stat_t       stat_z,
  input  logic [ogwa_pkg::LIM_W-1:0] lim,
  input  logic                       nonempty,
  output logic                       reject
);
  import ogwa_pkg::*;

  logic [SQ_W-1:0]  lim_sq_r;
  logic             reject_r;
  logic [ACC_W-1:0] acc;

  assign acc = ACC_W'(stat_x.sq) + ACC_W'(stat_y.sq) + ACC_W'(stat_z.sq);

  always_ff @(posedge clk) begin
    if (ctrl.square) begin
      lim_sq_r <= lim * lim;
    end
    if (ctrl.decide) begin
      reject_r <= nonempty &&
                  (stat_x.over || stat_y.over || stat_z.over || acc > ACC_W'(lim_sq_r));
    end
  end

  assign reject = reject_r;

endmodule

// ----- verif/outlier_gated_window_average_3d_unit_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// outlier_gated_window_average_3d_unit_checker
// Watches the position, result and register ports of the window average unit.
// It keeps its own window, sums and settings. For each accepted position it
// predicts the accept flag, the fill count and the rounded mean. Each result
// is compared with the oldest prediction, and mismatches are counted.
// ----------------------------------------------------------------------------
module outlier_gated_window_average_3d_unit_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  ogwa_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  ogwa_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [ogwa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ogwa_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatch_count,
  output int                              pending_count
);
  import ogwa_pkg::*;

  localparam int WIN_DEPTH = 16;

  int unsigned win_len;
  int unsigned radius;
  int unsigned fill;
  int unsigned oldest;
  longint      win_pos[WIN_DEPTH][3];
  longint      axis_sum[3];
  out_item_t   pending_means[$];
  int          fails = 0;

  function automatic logic signed [COORD_BITS-1:0] round_mean(longint s, int unsigned n);
    longint q;
    if (n == 0) return '0;
    q = ((s < 0) ? -s : s) + longint'(n / 2);
    q = q / longint'(n);
    if (s < 0) q = -q;
    return q[COORD_BITS-1:0];
  endfunction

  function automatic out_item_t fold_position(in_item_t p);
    longint      pos[3];
    longint      n;
    longint      lim;
    longint      d;
    longint      acc;
    bit          keep;
    int unsigned slot;
    out_item_t   r;
    pos[0] = longint'(p.pos_x);
    pos[1] = longint'(p.pos_y);
    pos[2] = longint'(p.pos_z);
    n      = longint'(fill);
    lim    = n * longint'(radius);
    acc    = 0;
    keep   = 1'b1;
    if (fill > 0) begin
      for (int i = 0; i < 3; i++) begin
        d = n * pos[i] - axis_sum[i];
        if (d < 0) d = -d;
        acc += d * d;
      end
      if (acc > lim * lim) keep = 1'b0;
    end
    if (keep) begin
      if (fill >= win_len) begin
        slot = oldest;
        for (int i = 0; i < 3; i++) axis_sum[i] -= win_pos[slot][i];
        oldest = oldest + 1;
        if (oldest >= win_len) oldest = 0;
      end else begin
        slot = oldest + fill;
        if (slot >= win_len) slot -= win_len;
        fill = fill + 1;
      end
      for (int i = 0; i < 3; i++) begin
        win_pos[slot][i] = pos[i];
        axis_sum[i] += pos[i];
      end
    end
    r.accepted   = keep;
    r.fill_count = LEN_W'(fill);
    r.mean_x     = round_mean(axis_sum[0], fill);
    r.mean_y     = round_mean(axis_sum[1], fill);
    r.mean_z     = round_mean(axis_sum[2], fill);
    return r;
  endfunction

  function automatic void clear_window();
    fill   = 0;
    oldest = 0;
    for (int i = 0; i < 3; i++) axis_sum[i] = 0;
  endfunction

  always @(posedge clk) begin
    int unsigned len_val;
    out_item_t   want;
    if (!rst_n) begin
      win_len = 16;
      radius  = 512;
      clear_window();
      pending_means.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW_LENGTH: begin
            len_val = cfg_data[LEN_W-1:0];
            if (len_val < 1) len_val = 1;
            if (len_val > WIN_DEPTH) len_val = WIN_DEPTH;
            win_len = len_val;
            clear_window();
          end
          REG_REJECT_RADIUS: begin
            radius = cfg_data[RAD_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall)
        pending_means.insert(pending_means.size(), fold_position(in_data));
      if (out_valid && !out_stall) begin
        if (pending_means.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected result: acc=%0d cnt=%0d mean=(%0d,%0d,%0d)",
                     out_data.accepted, out_data.fill_count,
                     out_data.mean_x, out_data.mean_y, out_data.mean_z);
        end else begin
          want = pending_means[0];
          pending_means.delete(0);
          if (out_data.accepted !== want.accepted ||
              out_data.fill_count !== want.fill_count ||
              out_data.mean_x !== want.mean_x ||
              out_data.mean_y !== want.mean_y ||
              out_data.mean_z !== want.mean_z) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: exp acc=%0d cnt=%0d mean=(%0d,%0d,%0d) got acc=%0d cnt=%0d %s",
                       want.accepted, want.fill_count, want.mean_x, want.mean_y,
                       want.mean_z, out_data.accepted, out_data.fill_count,
                       $sformatf("mean=(%0d,%0d,%0d)", out_data.mean_x,
                                 out_data.mean_y, out_data.mean_z));
          end
        end
      end
    end
    mismatch_count <= fails;
    pending_count  <= pending_means.size();
  end

endmodule

// ----- verif/outlier_gated_window_average_3d_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// outlier_gated_window_average_3d_unit_test
// Drives positions and register writes into the window average unit with
// random gaps and result stalls. A directed part covers the coordinate
// extremes, radius zero, rounding ties and clamped window lengths. Random
// phases then cluster positions around a center at spreads tied to the
// radius, mixed with full range noise. The checker beside the unit predicts
// and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module outlier_gated_window_average_3d_unit_test;
  import ogwa_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_GAP      = 6;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 170;
  localparam int POS_MAX      = 524287;
  localparam int POS_MIN      = -524288;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  in_item_t              in_data   = '0;
  logic                  out_stall = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_stall;
  logic                  out_valid;
  out_item_t             out_data;
  int                    mismatch_count;
  int                    pending_count;
  int                    cycle_count = 0;
  int                    gap_max     = MAX_GAP;

  always #10 clk = ~clk;

  outlier_gated_window_average_3d_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  outlier_gated_window_average_3d_unit_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic in_item_t mk(int x, int y, int z);
    in_item_t it;
    it.pos_x = x[COORD_BITS-1:0];
    it.pos_y = y[COORD_BITS-1:0];
    it.pos_z = z[COORD_BITS-1:0];
    return it;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(7, 0))
      0:       return {1'b0, {(COORD_BITS-1){1'b1}}};
      1:       return {1'b1, {(COORD_BITS-1){1'b0}}};
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  function automatic int near_coord(int center, int spread);
    int v;
    v = center + int'($urandom_range(2 * spread, 0)) - spread;
    if (v > POS_MAX) v = POS_MAX;
    if (v < POS_MIN) v = POS_MIN;
    return v;
  endfunction

  task automatic send_pos(input in_item_t item);
    int gap;
    bit taken;
    gap = $urandom_range(gap_max, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reconfigure(input int len, input int rad);
    drain();
    write_reg(REG_WINDOW_LENGTH, CFG_DATA_W'(len));
    write_reg(REG_REJECT_RADIUS, CFG_DATA_W'(rad));
  endtask

  initial begin : result_sink
    int hold;
    bit taken;
    wait (rst_n);
    @(posedge clk);
    forever begin
      hold = $urandom_range(gap_max, 0);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do begin
        @(negedge clk);
        taken = out_valid;
        @(posedge clk);
      end while (!taken);
    end
  end

  initial begin : stimulus
    int       rad;
    int       len_val;
    int       spread;
    int       sel;
    int       cx;
    int       cy;
    int       cz;
    in_item_t item;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: length 16, radius 512
    send_pos(mk(POS_MAX, POS_MAX, POS_MAX));
    send_pos(mk(POS_MIN, POS_MIN, POS_MIN));
    send_pos(mk(POS_MAX, POS_MAX, POS_MAX - 512));
    send_pos(mk(POS_MAX - 300, POS_MAX, POS_MAX - 700));

    // rounding ties on both signs, then drop of the oldest
    reconfigure(2, 3);
    send_pos(mk(-1, -2, 1));
    send_pos(mk(0, -1, 2));
    send_pos(mk(0, -1, 2));

    // zero radius, length zero acts as one
    reconfigure(0, 0);
    send_pos(mk(5, 5, 5));
    send_pos(mk(6, 5, 5));
    send_pos(mk(5, 5, 5));
    send_pos(mk(5, 5, -5));

    // length above the maximum, widest radius
    reconfigure(31, 65535);
    send_pos(mk(POS_MAX, POS_MIN, 0));
    send_pos(mk(POS_MIN, POS_MAX, 0));
    send_pos(mk(POS_MAX - 65535, POS_MIN + 40000, 'h2AAAA));
    send_pos(mk(POS_MAX - 20000, POS_MIN + 1, -'h15555));

    // radius change keeps the window
    drain();
    write_reg(REG_REJECT_RADIUS, 16'd100);
    send_pos(mk(POS_MAX - 30000, POS_MIN + 30000, 0));
    send_pos(mk(POS_MAX - 30050, POS_MIN + 30020, 10));

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      drain();
      gap_max = (phase % 4 == 3) ? 0 : MAX_GAP;
      case (phase)
        0:       len_val = 1;
        1:       len_val = 16;
        2:       len_val = 0;
        3:       len_val = 31;
        default: len_val = $urandom_range(1, 0) ? $urandom_range(31, 0) : $urandom;
      endcase
      case (phase)
        0:       rad = 0;
        1:       rad = 65535;
        2:       rad = 512;
        3:       rad = 65535;
        default: begin
          case ($urandom_range(3, 0))
            0:       rad = $urandom_range(65535, 0);
            1:       rad = $urandom_range(64, 0);
            2:       rad = $urandom_range(4000, 1);
            default: rad = 65535;
          endcase
        end
      endcase
      if (phase < 4 || $urandom_range(3, 0) != 0)
        write_reg(REG_WINDOW_LENGTH, CFG_DATA_W'(len_val));
      write_reg(REG_REJECT_RADIUS, CFG_DATA_W'(rad));
      cx = int'(pick_coord());
      cy = int'(pick_coord());
      cz = int'(pick_coord());
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(19, 0) == 0) begin
          cx = int'(pick_coord());
          cy = int'(pick_coord());
          cz = int'(pick_coord());
        end
        sel = $urandom_range(9, 0);
        case (sel)
          1, 2, 3, 4, 5: spread = rad / 2;
          6, 7:          spread = rad;
          default:       spread = 2 * rad + 2;
        endcase
        if (sel == 0)
          item = mk(int'(pick_coord()), int'(pick_coord()), int'(pick_coord()));
        else
          item = mk(near_coord(cx, spread), near_coord(cy, spread), near_coord(cz, spread));
        send_pos(item);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- outlier_gated_window_average_3d_unit.f -----
design/ogwa_pkg.sv
design/ogwa_lane.sv
design/ogwa_merge.sv
design/outlier_gated_window_average_3d_unit.sv
verif/outlier_gated_window_average_3d_unit_checker.sv
verif/outlier_gated_window_average_3d_unit_test.sv
